>>> rtl/trht_pkg.sv
// ----------------------------------------------------------------------------
// trht_pkg: shared types and constants for the tuning record hash table
// Key word codes, status codes, opcodes and controller states.
// ----------------------------------------------------------------------------
package trht_pkg;

  localparam int KEY_W = 16;               // stored key word
  localparam int SET_W = 24;               // cap_in | cap_out | inductor
  localparam int BLK_W = 13;               // key bits 15..3, source of home slot

  localparam logic [KEY_W-1:0] KEY_MASK    = 16'hfff8;
  localparam logic [KEY_W-1:0] WORD_EMPTY  = 16'h0000;
  localparam logic [KEY_W-1:0] WORD_ERASED = 16'hffff;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,                        // hit or stored
    ST_MISS = 2'd1,                        // not found
    ST_FULL = 2'd2                         // table full
  } status_t;

  typedef enum logic {
    OP_FIND  = 1'b0,
    OP_STORE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    S_CLEAR,                               // erase sweep after reset
    S_IDLE,                                // waiting for a request word
    S_READ,                                // memory read issued
    S_CHECK                                // slot word examined
  } state_t;

endpackage

>>> rtl/trht_ram.sv
// ----------------------------------------------------------------------------
// trht_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module trht_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/trht_home.sv
// ----------------------------------------------------------------------------
// trht_home: home slot of a key
// Reduces key bits 15..3 modulo SLOTS by restoring compare-subtract steps;
// steps whose shifted divisor exceeds the key range drop out at elaboration.
// ----------------------------------------------------------------------------
module trht_home #(
  parameter int SLOTS = 256
) (
  input  logic [trht_pkg::BLK_W-1:0] blk,
  output logic [$clog2(SLOTS)-1:0]   home
);

  localparam int          IW    = $clog2(SLOTS);
  localparam logic [31:0] BLK_MAX = (32'd1 << trht_pkg::BLK_W) - 32'd1;

  always_comb begin
    logic [trht_pkg::BLK_W-1:0] r;
    logic [31:0]                sub_c;
    r = blk;
    for (int k = trht_pkg::BLK_W - 1; k >= 0; k--) begin
      sub_c = 32'(SLOTS) << k;
      if (sub_c <= BLK_MAX && {{(32 - trht_pkg::BLK_W){1'b0}}, r} >= sub_c) begin
        r = r - sub_c[trht_pkg::BLK_W-1:0];
      end
    end
    home = r[IW-1:0];
  end

endmodule

>>> rtl/tuning_record_hash_table.sv
// ----------------------------------------------------------------------------
// tuning_record_hash_table: open-addressing table of tuner settings
// Maps a frequency key to three 8-bit settings with linear probing.
// ----------------------------------------------------------------------------
// Each request word carries an opcode in s_tuser (find or store), a 16-bit
// frequency key whose low 3 bits are ignored, and three settings used by a
// store. The home slot is (key >> 3) mod SLOTS; the probe walks forward one
// slot at a time and wraps. A slot word of 0x0000 is empty, 0xffff is erased.
// A find stops on a matching key or an empty slot and skips erased slots; a
// store also stops on an erased slot and claims it. Exactly one result word
// comes back per request: status in m_tuser, settings in m_tdata on a find
// hit (zero otherwise). Each probe is one read of the key and settings
// memories in S_READ followed by an examination of the word in S_CHECK;
// a request probes from 1 up to SLOTS slots. After reset the block runs
// an erase sweep that writes the erased word to every slot of the key
// memory and takes no request until it is done. A new request is taken
// while the previous result still waits in the output register; the block
// only holds a finished probe when that register is still occupied.
// ----------------------------------------------------------------------------
module tuning_record_hash_table #(
  parameter int SLOTS = 256
) (
  input  logic        clk,
  input  logic        rst,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // freq_key[15:0], cap_in[23:16],
                                 // cap_out[31:24], inductor[39:32]
  input  logic        s_tuser,   // opcode[0]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // found_cap_in[7:0], found_cap_out[15:8],
                                 // found_inductor[23:16]
  output logic [1:0]  m_tuser    // status[1:0]
);

  localparam int            IW   = $clog2(SLOTS);
  localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

  trht_pkg::state_t state, state_next;

  // request context
  logic [IW-1:0]                idx, idx_next;   // probe slot / sweep address
  logic [IW-1:0]                cnt, cnt_next;   // slots probed so far
  trht_pkg::op_t                op;
  logic [trht_pkg::KEY_W-1:0]   keym;
  logic [trht_pkg::SET_W-1:0]   set_in;

  logic [IW-1:0]                home;
  logic                         s_acc;

  // memory ports
  logic                         key_we;
  logic [trht_pkg::KEY_W-1:0]   key_wdata;
  logic [trht_pkg::KEY_W-1:0]   key_rd;
  logic                         set_we;
  logic [trht_pkg::SET_W-1:0]   set_rd;
  logic                         rd_en;

  // slot decode
  logic                         is_match, is_empty, is_erased, is_last;
  logic                         stop, done, out_free, out_load;
  trht_pkg::status_t            res_status;
  logic [trht_pkg::SET_W-1:0]   res_set;

  // home slot from key bits 15..3
  trht_home #(.SLOTS(SLOTS)) u_home (
    .blk  (s_tdata[15:3]),
    .home (home)
  );

  trht_ram #(.WIDTH(trht_pkg::KEY_W), .DEPTH(SLOTS)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (idx),
    .wdata (key_wdata),
    .re    (rd_en),
    .raddr (idx),
    .rdata (key_rd)
  );

  trht_ram #(.WIDTH(trht_pkg::SET_W), .DEPTH(SLOTS)) u_set_ram (
    .clk   (clk),
    .we    (set_we),
    .waddr (idx),
    .wdata (set_in),
    .re    (rd_en),
    .raddr (idx),
    .rdata (set_rd)
  );

  assign s_tready = (state == trht_pkg::S_IDLE);
  assign s_acc    = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // slot word examined in S_CHECK; the read data holds until the next read
  assign is_match  = (key_rd == keym);
  assign is_empty  = (key_rd == trht_pkg::WORD_EMPTY);
  assign is_erased = (key_rd == trht_pkg::WORD_ERASED);
  assign is_last   = (cnt == LAST);

  always_comb begin
    if (op == trht_pkg::OP_STORE) begin
      stop = is_match || is_empty || is_erased;
    end else begin
      stop = is_match || is_empty;
    end
    done = stop || is_last;

    // find: decided by the stop slot, or the last slot of a full walk
    res_set = '0;
    if (op == trht_pkg::OP_STORE) begin
      res_status = stop ? trht_pkg::ST_OK : trht_pkg::ST_FULL;
    end else if (is_match) begin
      res_status = trht_pkg::ST_OK;
      res_set    = set_rd;
    end else if (is_empty || is_erased) begin
      res_status = trht_pkg::ST_MISS;
    end else begin
      res_status = trht_pkg::ST_FULL;
    end
  end

  // next state and memory controls
  always_comb begin
    state_next = state;
    idx_next   = idx;
    cnt_next   = cnt;
    key_we     = 1'b0;
    key_wdata  = keym;
    set_we     = 1'b0;
    rd_en      = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      trht_pkg::S_CLEAR: begin
        key_we    = 1'b1;
        key_wdata = trht_pkg::WORD_ERASED;
        idx_next  = idx + IW'(1);
        if (idx == LAST) begin
          state_next = trht_pkg::S_IDLE;
        end
      end
      trht_pkg::S_IDLE: begin
        if (s_acc) begin
          idx_next   = home;
          cnt_next   = '0;
          state_next = trht_pkg::S_READ;
        end
      end
      trht_pkg::S_READ: begin
        rd_en      = 1'b1;
        state_next = trht_pkg::S_CHECK;
      end
      trht_pkg::S_CHECK: begin
        if (done) begin
          if (out_free) begin
            out_load   = 1'b1;
            key_we     = (op == trht_pkg::OP_STORE) && stop;
            set_we     = (op == trht_pkg::OP_STORE) && stop;
            state_next = trht_pkg::S_IDLE;
          end
        end else begin
          // linear probe with wrap
          idx_next   = (idx == LAST) ? '0 : idx + IW'(1);
          cnt_next   = cnt + IW'(1);
          state_next = trht_pkg::S_READ;
        end
      end
      default: state_next = trht_pkg::S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= trht_pkg::S_CLEAR;
      idx   <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      cnt   <= cnt_next;
    end
  end

  // request payload
  always_ff @(posedge clk) begin
    if (s_acc) begin
      op     <= trht_pkg::op_t'(s_tuser);
      keym   <= s_tdata[15:0] & trht_pkg::KEY_MASK;
      set_in <= {s_tdata[23:16], s_tdata[31:24], s_tdata[39:32]};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tuser <= res_status;
      m_tdata <= {res_set[7:0], res_set[15:8], res_set[23:16]};
    end
  end

  // a result appears only out of a slot check
  a_result_from_check: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == trht_pkg::S_CHECK)
    else $error("result raised outside slot check");

  // a find never modifies the table
  a_find_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == trht_pkg::S_CHECK && op == trht_pkg::OP_FIND) |-> !key_we && !set_we)
    else $error("find wrote the table");

  // settings only come back on a hit
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != trht_pkg::ST_OK) |-> m_tdata == '0)
    else $error("settings returned without a hit");

  // every read is examined in the next cycle
  a_read_then_check: assert property (@(posedge clk) disable iff (rst)
    state == trht_pkg::S_READ |=> state == trht_pkg::S_CHECK)
    else $error("read not followed by slot check");

  // a table write is a sweep write or a store that completes
  a_write_source: assert property (@(posedge clk) disable iff (rst)
    key_we |-> (state == trht_pkg::S_CLEAR) ||
               (state == trht_pkg::S_CHECK && op == trht_pkg::OP_STORE && out_free))
    else $error("unexpected key write");

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for tuning_record_hash_table
// Sends find and store request words on the slave stream. It predicts every
// result word with its own copy of the key and settings tables, and checks
// the master stream in order. Idling and stalls are random.
// ----------------------------------------------------------------------------
module testbench;

  localparam int TABLE_SLOTS = 256;
  localparam int POOL_N      = 150;   // keys reused by the random traffic
  localparam int MAX_REPORTS = 200;   // keep a broken run's log readable

  // one request word as the sender sees it; drain holds the word back
  // until every earlier result has come home
  typedef struct {
    trht_pkg::op_t op;
    logic [15:0]   freq_key;
    logic [7:0]    cap_in;
    logic [7:0]    cap_out;
    logic [7:0]    inductor;
    bit            drain;
  } request_t;

  typedef struct {
    trht_pkg::status_t status;
    logic [7:0]        cap_in;
    logic [7:0]        cap_out;
    logic [7:0]        inductor;
  } reply_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata  = '0;   // freq_key[15:0], cap_in[23:16],
                                // cap_out[31:24], inductor[39:32]
  logic        s_tuser  = 1'b0; // opcode[0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;         // found_cap_in[7:0], found_cap_out[15:8],
                                // found_inductor[23:16]
  logic [1:0]  m_tuser;         // status[1:0]

  // shadow copy of the table contents
  logic [15:0] key_mem [TABLE_SLOTS];
  logic [23:0] set_mem [TABLE_SLOTS];

  request_t request_q[$];   // words not yet offered
  reply_t   reply_q[$];     // predicted result words, oldest first
  request_t cur_req;        // word currently on the slave bus
  int       sent_count  = 0;
  int       reply_count = 0;
  int       fault_count = 0;
  int       hold_left   = 0;
  bit       hold_done   = 1'b0;

  tuning_record_hash_table #(
    .SLOTS(TABLE_SLOTS)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Works out the result of one request and updates the shadow table.
  // Linear probe from the home slot, wrapping, each slot visited once.
  // A find skips erased slots; a store claims the first empty or erased
  // slot. A walk with no stop leaves idx on the last slot probed.
  function automatic reply_t apply_request(request_t rq);
    reply_t      rp;
    logic [15:0] keym;
    logic [15:0] w;
    int          home;
    int          idx;
    int          n;
    bit          stopped;
    rp.status   = trht_pkg::ST_OK;
    rp.cap_in   = 8'h00;
    rp.cap_out  = 8'h00;
    rp.inductor = 8'h00;
    keym    = rq.freq_key & trht_pkg::KEY_MASK;
    home    = int'(rq.freq_key >> 3) % TABLE_SLOTS;
    idx     = home;
    stopped = 1'b0;
    for (n = 0; n < TABLE_SLOTS && !stopped; n++) begin
      idx = (home + n) % TABLE_SLOTS;
      w   = key_mem[idx];
      if (w == keym || w == trht_pkg::WORD_EMPTY ||
          (rq.op == trht_pkg::OP_STORE && w == trht_pkg::WORD_ERASED))
        stopped = 1'b1;
    end
    if (rq.op == trht_pkg::OP_STORE) begin
      if (stopped) begin
        key_mem[idx] = keym;
        set_mem[idx] = {rq.cap_in, rq.cap_out, rq.inductor};
      end else begin
        rp.status = trht_pkg::ST_FULL;
      end
    end else begin
      w = key_mem[idx];
      if (w == keym) begin
        rp.cap_in   = set_mem[idx][23:16];
        rp.cap_out  = set_mem[idx][15:8];
        rp.inductor = set_mem[idx][7:0];
      end else if (w == trht_pkg::WORD_EMPTY || w == trht_pkg::WORD_ERASED) begin
        rp.status = trht_pkg::ST_MISS;
      end else begin
        // walked every slot; the last one holds a foreign key
        rp.status = trht_pkg::ST_FULL;
      end
    end
    return rp;
  endfunction

  task automatic push_req(input trht_pkg::op_t op, input logic [15:0] key,
                          input logic [23:0] set, input bit drain);
    request_t rq;
    rq.op       = op;
    rq.freq_key = key;
    rq.cap_in   = set[23:16];
    rq.cap_out  = set[15:8];
    rq.inductor = set[7:0];
    rq.drain    = drain;
    request_q.push_back(rq);
  endtask

  // Sender: a prediction is made at the edge where a word is taken, so the
  // shadow table follows the exact order of acceptance.
  always @(posedge clk) begin : drive_requests
    request_t nxt;
    bit       go;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        reply_q.push_back(apply_request(cur_req));
        sent_count++;
      end
      if (!s_tvalid || s_tready) begin
        go = request_q.size() != 0;
        // pause: hold the marked word until the block has drained
        if (go && request_q[0].drain && reply_q.size() != 0)
          go = 1'b0;
        // random gaps, except in a quiet stretch
        if (go && !(sent_count >= 400 && sent_count < 700) && $urandom_range(99) < 18)
          go = 1'b0;
        if (go) begin
          nxt      = request_q.pop_front();
          cur_req  = nxt;
          s_tvalid <= 1'b1;
          s_tdata  <= {nxt.inductor, nxt.cap_out, nxt.cap_in, nxt.freq_key};
          s_tuser  <= nxt.op;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result word against the oldest prediction and
  // drives m_tready, with one long hold-off so the block backs up.
  always @(posedge clk) begin : check_replies
    reply_t exp_r;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        reply_count++;
        if (reply_q.size() == 0) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS)
            $display("%0t: unexpected result word: expected none, got status %0d data %h",
                     $time, m_tuser, m_tdata);
        end else begin
          exp_r = reply_q.pop_front();
          if (m_tuser !== exp_r.status || m_tdata[7:0] !== exp_r.cap_in ||
              m_tdata[15:8] !== exp_r.cap_out || m_tdata[23:16] !== exp_r.inductor) begin
            fault_count++;
            if (fault_count <= MAX_REPORTS)
              $display({"%0t: result mismatch: expected status %0d cap_in %h cap_out %h",
                        " ind %h, got status %0d cap_in %h cap_out %h ind %h"},
                       $time, exp_r.status, exp_r.cap_in, exp_r.cap_out, exp_r.inductor,
                       m_tuser, m_tdata[7:0], m_tdata[15:8], m_tdata[23:16]);
          end
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (!hold_done && reply_count == 1000) begin
        // long back-pressure while the sender keeps offering
        hold_done = 1'b1;
        hold_left = 300;
        m_tready  <= 1'b0;
      end else if (reply_count >= 400 && reply_count < 700) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(99) >= 18);
      end
    end
  end

  initial begin : stimulus
    logic [15:0] key_pool [POOL_N];
    logic [15:0] key;
    logic [15:0] rnd16;
    logic [23:0] settings;
    int          pick;
    int          i;

    for (i = 0; i < TABLE_SLOTS; i++) begin
      key_mem[i] = trht_pkg::WORD_ERASED;
      set_mem[i] = '0;
    end
    for (i = 0; i < POOL_N; i++) begin
      rnd16       = 16'($urandom);
      key_pool[i] = rnd16 & trht_pkg::KEY_MASK;
    end

    // directed: erased table, key zero, top key with wrap, empty-slot
    // claims, updates, settings extremes, low key bits ignored
    push_req(trht_pkg::OP_FIND,  16'h1234, 24'h000000, 1'b0);  // all erased: miss
    push_req(trht_pkg::OP_STORE, 16'h0005, 24'hff00ff, 1'b0);  // key zero
    push_req(trht_pkg::OP_FIND,  16'h0002, 24'h000000, 1'b0);
    push_req(trht_pkg::OP_FIND,  16'h0008, 24'h000000, 1'b0);  // stops on empty slot
    push_req(trht_pkg::OP_STORE, 16'hffff, 24'h00ff00, 1'b0);  // home = last slot
    push_req(trht_pkg::OP_FIND,  16'hfff8, 24'h000000, 1'b0);
    push_req(trht_pkg::OP_STORE, 16'h07ff, 24'h123456, 1'b0);  // wraps, takes empty slot
    push_req(trht_pkg::OP_FIND,  16'h07fa, 24'h000000, 1'b0);
    push_req(trht_pkg::OP_FIND,  16'h0000, 24'h000000, 1'b0);  // full walk, foreign last
    push_req(trht_pkg::OP_STORE, 16'h0000, 24'habcdef, 1'b0);
    push_req(trht_pkg::OP_FIND,  16'h0007, 24'h000000, 1'b0);
    push_req(trht_pkg::OP_STORE, 16'hfff9, 24'ha55ac3, 1'b0);  // update in place
    push_req(trht_pkg::OP_FIND,  16'hfffe, 24'h000000, 1'b0);
    push_req(trht_pkg::OP_STORE, 16'h0800, 24'hffffff, 1'b0);  // lands on key zero's slot
    push_req(trht_pkg::OP_FIND,  16'h0803, 24'h000000, 1'b0);
    push_req(trht_pkg::OP_FIND,  16'h0001, 24'h000000, 1'b0);
    push_req(trht_pkg::OP_STORE, 16'h8000, 24'h000000, 1'b0);
    push_req(trht_pkg::OP_FIND,  16'h8007, 24'h000000, 1'b0);
    push_req(trht_pkg::OP_FIND,  16'h7ff8, 24'h000000, 1'b0);

    // random mix over a reused key pool; pause once mid-way
    for (i = 0; i < 1100; i++) begin
      pick     = $urandom_range(99);
      settings = 24'($urandom);
      rnd16    = 16'($urandom);
      key      = key_pool[$urandom_range(POOL_N - 1)];
      key[2:0] = rnd16[2:0];
      if (pick < 45)
        push_req(trht_pkg::OP_STORE, key, settings, i == 550);
      else if (pick < 80)
        push_req(trht_pkg::OP_FIND, key, settings, i == 550);
      else if (pick < 88)
        push_req(trht_pkg::OP_FIND, rnd16, settings, i == 550);
      else if (pick < 95)
        push_req(trht_pkg::OP_STORE, rnd16, settings, i == 550);
      else
        push_req(pick[0] ? trht_pkg::OP_STORE : trht_pkg::OP_FIND,
                 {13'd0, rnd16[2:0]}, settings, i == 550);
    end

    // fill the table up and keep storing past full
    for (i = 0; i < 300; i++) begin
      pick     = $urandom_range(99);
      settings = 24'($urandom);
      rnd16    = 16'($urandom);
      key      = key_pool[$urandom_range(POOL_N - 1)];
      key[2:0] = rnd16[2:0];
      if (pick < 80)
        push_req(trht_pkg::OP_STORE, rnd16, settings, i == 0);
      else
        push_req(trht_pkg::OP_FIND, key, settings, i == 0);
    end

    // full table: misses walk every slot, hits and updates still work
    for (i = 0; i < 250; i++) begin
      pick     = $urandom_range(99);
      settings = 24'($urandom);
      rnd16    = 16'($urandom);
      key      = key_pool[$urandom_range(POOL_N - 1)];
      key[2:0] = rnd16[2:0];
      if (pick < 25)
        push_req(trht_pkg::OP_FIND, rnd16, settings, 1'b0);
      else if (pick < 65)
        push_req(trht_pkg::OP_FIND, key, settings, 1'b0);
      else if (pick < 90)
        push_req(trht_pkg::OP_STORE, key, settings, 1'b0);
      else
        push_req(pick[0] ? trht_pkg::OP_STORE : trht_pkg::OP_FIND,
                 {13'd0, rnd16[2:0]}, settings, 1'b0);
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (request_q.size() != 0 || s_tvalid || reply_q.size() != 0)
      @(posedge clk);
    // allow for a stray late word
    repeat (600) @(posedge clk);

    if (fault_count == 0) begin
      $display("tuning_record_hash_table: match");
    end else begin
      $display("tuning_record_hash_table: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #50000000;
    $display("tuning_record_hash_table: mismatch");
    $finish;
  end

endmodule
